### src/cips_pkg.sv
// Shared types, codes and constants for the cascaded incremental PID servo.
`timescale 1ns / 1ps

package cips_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_BITS_DEF = 32;
  localparam int FIELD_W       = 32;
  localparam int GAIN_W        = 32;
  localparam int LIM_W         = 31;
  localparam int CFG_IDX_W     = 3;

  localparam logic [CFG_IDX_W-1:0] REG_POS_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KI    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_KD    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPD_LIMIT = 3'd7;

  localparam logic [LIM_W-1:0] LIMIT_RESET = '1;

  localparam logic MODE_SPEED = 1'b0;
  localparam logic MODE_POS   = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] target;
    logic signed [FIELD_W-1:0] angle_feedback;
    logic signed [FIELD_W-1:0] rpm_feedback;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] drive;
    logic signed [FIELD_W-1:0] speed_setpoint;
  } out_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ERR,
    OP_DIFF,
    OP_MLO,
    OP_MHI,
    OP_PROD,
    OP_ACC,
    OP_CLAMP,
    OP_OUT
  } op_t;

  typedef enum logic [1:0] {
    TERM_P,
    TERM_I,
    TERM_D
  } term_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_PROD,
    ST_ACC,
    ST_CLAMP,
    ST_OUT
  } state_t;

  typedef struct packed {
    op_t   op;
    logic  loop_pos;
    term_t term;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic out_free;
  } stat_t;

endpackage

### src/cips_ctrl.sv
// Sequencer for the servo: steps both PID loops through the shared datapath.
`timescale 1ns / 1ps

module cips_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  cips_pkg::stat_t stat,
  output cips_pkg::cmd_t  cmd
);
  import cips_pkg::*;

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;
  logic   loop_pos_r, loop_pos_nxt;
  logic   loop_pos_eff;

  assign loop_pos_eff = loop_pos_r && (stat.mode == MODE_POS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      term_r     <= TERM_P;
      loop_pos_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      term_r     <= term_nxt;
      loop_pos_r <= loop_pos_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    term_nxt     = term_r;
    loop_pos_nxt = loop_pos_r;
    in_stall     = 1'b1;
    cmd.op       = OP_NONE;
    cmd.term     = term_r;
    cmd.loop_pos = loop_pos_eff;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op       = OP_LOAD;
          loop_pos_nxt = 1'b1;
          state_nxt    = ST_ERR;
        end
      end
      ST_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.op    = OP_DIFF;
        term_nxt  = TERM_P;
        state_nxt = ST_MLO;
      end
      ST_MLO: begin
        cmd.op    = OP_MLO;
        state_nxt = ST_MHI;
      end
      ST_MHI: begin
        cmd.op    = OP_MHI;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.op    = OP_PROD;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.op = OP_ACC;
        if (term_r == TERM_D) begin
          state_nxt = ST_CLAMP;
        end else begin
          state_nxt = ST_MLO;
          unique case (term_r)
            TERM_P:  term_nxt = TERM_I;
            TERM_I:  term_nxt = TERM_D;
            default: term_nxt = TERM_P;
          endcase
        end
      end
      ST_CLAMP: begin
        cmd.op = OP_CLAMP;
        if (loop_pos_eff) begin
          loop_pos_nxt = 1'b0;
          state_nxt    = ST_ERR;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### src/cips_dp.sv
// Servo datapath: gain registers, loop state, error terms, split multiplier, clamp.
`timescale 1ns / 1ps

module cips_dp #(
  parameter int FRAC_BITS = cips_pkg::FRAC_BITS_DEF,
  parameter int DATA_BITS = cips_pkg::DATA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cips_pkg::cmd_t                      cmd,
  output cips_pkg::stat_t                     stat,
  input  cips_pkg::in_req_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output cips_pkg::out_rsp_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cips_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cips_pkg::FIELD_W-1:0]        cfg_data
);
  import cips_pkg::*;

  localparam int DW   = DATA_BITS;
  localparam int HALF = DATA_BITS / 2;
  localparam int PLW  = GAIN_W + HALF + 1;
  localparam int PHW  = GAIN_W + DW - HALF;
  localparam int PW   = GAIN_W + DW;
  localparam int CW   = DW + 32;

  localparam logic signed [DW+1:0] W_MAX = {3'b000, {(DW-1){1'b1}}};
  localparam logic signed [DW+1:0] W_MIN = {3'b111, {(DW-1){1'b0}}};
  localparam logic signed [PW-1:0] P_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [PW-1:0] P_MIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [CW-1:0] I_MAX = {{33{1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [CW-1:0] I_MIN = {{33{1'b1}}, {(DW-1){1'b0}}};

  function automatic logic signed [DW-1:0] sat_w(input logic signed [DW+1:0] x);
    logic signed [DW-1:0] r;
    if (x > W_MAX)      r = W_MAX[DW-1:0];
    else if (x < W_MIN) r = W_MIN[DW-1:0];
    else                r = x[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat_p(input logic signed [PW-1:0] x);
    logic signed [DW-1:0] r;
    if (x > P_MAX)      r = P_MAX[DW-1:0];
    else if (x < P_MIN) r = P_MIN[DW-1:0];
    else                r = x[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW-1:0] sat_i(input logic signed [FIELD_W-1:0] x);
    logic signed [CW-1:0] w;
    logic signed [DW-1:0] r;
    w = {{DW{x[FIELD_W-1]}}, x};
    if (w > I_MAX)      r = I_MAX[DW-1:0];
    else if (w < I_MIN) r = I_MIN[DW-1:0];
    else                r = w[DW-1:0];
    return r;
  endfunction

  function automatic logic signed [DW+1:0] ext2(input logic signed [DW-1:0] x);
    return {{2{x[DW-1]}}, x};
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic signed [DW-1:0] x);
    logic [CW-1:0] w;
    w = {{32{x[DW-1]}}, x};
    return w[FIELD_W-1:0];
  endfunction

  // configuration
  logic signed [GAIN_W-1:0] pos_kp_r, pos_ki_r, pos_kd_r;
  logic signed [GAIN_W-1:0] spd_kp_r, spd_ki_r, spd_kd_r;
  logic [LIM_W-1:0]         pos_limit_r, spd_limit_r;

  // loop state
  logic signed [DW-1:0] pos_acc_r, pos_e1_r, pos_e2_r;
  logic signed [DW-1:0] spd_acc_r, spd_e1_r, spd_e2_r;

  // working registers
  logic                 mode_r;
  logic signed [DW-1:0] target_r, angle_r, rpm_r, sp_r;
  logic signed [DW-1:0] e_r, d1_r, d2_r, prod_r;
  logic signed [DW+1:0] sum_r;
  logic signed [PLW-1:0] plo_r;
  logic signed [PHW-1:0] phi_r;
  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  logic signed [DW-1:0]     ref_v, fdb_v, e1_v, e2_v, acc_v, term_v;
  logic signed [GAIN_W-1:0] gain_v;
  logic [LIM_W-1:0]         lim_v;
  logic signed [DW+1:0]     err_wide, d1_wide, d2_wide, sum_nxt;
  logic signed [DW-1:0]     e_nxt, d1_nxt, d2_nxt, prod_nxt, clamp_nxt, s_sat;
  logic signed [PLW-1:0]    plo_nxt;
  logic signed [PHW-1:0]    phi_nxt;
  logic signed [PW-1:0]     full_prod, shifted;
  logic signed [CW-1:0]     s_c, lim_c, nlim_c, res_c;

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.mode     = mode_r;
  assign stat.out_free = !out_valid_r || !out_stall;

  always_comb begin
    ref_v = cmd.loop_pos ? target_r : sp_r;
    fdb_v = cmd.loop_pos ? angle_r : rpm_r;
    e1_v  = cmd.loop_pos ? pos_e1_r : spd_e1_r;
    e2_v  = cmd.loop_pos ? pos_e2_r : spd_e2_r;
    acc_v = cmd.loop_pos ? pos_acc_r : spd_acc_r;
    lim_v = cmd.loop_pos ? pos_limit_r : spd_limit_r;
    unique case (cmd.term)
      TERM_P: begin
        gain_v = cmd.loop_pos ? pos_kp_r : spd_kp_r;
        term_v = d1_r;
      end
      TERM_I: begin
        gain_v = cmd.loop_pos ? pos_ki_r : spd_ki_r;
        term_v = e_r;
      end
      TERM_D: begin
        gain_v = cmd.loop_pos ? pos_kd_r : spd_kd_r;
        term_v = d2_r;
      end
      default: begin
        gain_v = '0;
        term_v = '0;
      end
    endcase
  end

  always_comb begin
    err_wide = ext2(ref_v) - ext2(fdb_v);
    e_nxt    = sat_w(err_wide);
    d1_wide  = ext2(e_r) - ext2(e1_v);
    d2_wide  = ext2(e_r) - (ext2(e1_v) <<< 1) + ext2(e2_v);
    d1_nxt   = sat_w(d1_wide);
    d2_nxt   = sat_w(d2_wide);

    // gain times term in two partial products: low half unsigned, high half signed
    plo_nxt  = PLW'(gain_v) * PLW'($signed({1'b0, term_v[HALF-1:0]}));
    phi_nxt  = PHW'(gain_v) * PHW'($signed(term_v[DW-1:HALF]));

    full_prod = $signed({phi_r, {HALF{1'b0}}})
              + $signed({{(PW-PLW){plo_r[PLW-1]}}, plo_r});
    shifted   = full_prod >>> FRAC_BITS;
    prod_nxt  = sat_p(shifted);

    sum_nxt   = sum_r + ext2(prod_r);

    s_sat  = sat_w(sum_r);
    s_c    = {{32{s_sat[DW-1]}}, s_sat};
    lim_c  = {{(CW-LIM_W){1'b0}}, lim_v};
    nlim_c = -lim_c;
    if (s_c > lim_c)       res_c = lim_c;
    else if (s_c < nlim_c) res_c = nlim_c;
    else                   res_c = s_c;
    clamp_nxt = res_c[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_kp_r    <= '0;
      pos_ki_r    <= '0;
      pos_kd_r    <= '0;
      pos_limit_r <= LIMIT_RESET;
      spd_kp_r    <= '0;
      spd_ki_r    <= '0;
      spd_kd_r    <= '0;
      spd_limit_r <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POS_KP:    pos_kp_r    <= cfg_data;
        REG_POS_KI:    pos_ki_r    <= cfg_data;
        REG_POS_KD:    pos_kd_r    <= cfg_data;
        REG_POS_LIMIT: pos_limit_r <= cfg_data[LIM_W-1:0];
        REG_SPD_KP:    spd_kp_r    <= cfg_data;
        REG_SPD_KI:    spd_ki_r    <= cfg_data;
        REG_SPD_KD:    spd_kd_r    <= cfg_data;
        REG_SPD_LIMIT: spd_limit_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_acc_r <= '0;
      pos_e1_r  <= '0;
      pos_e2_r  <= '0;
      spd_acc_r <= '0;
      spd_e1_r  <= '0;
      spd_e2_r  <= '0;
    end else if (cmd.op == OP_CLAMP) begin
      if (cmd.loop_pos) begin
        pos_acc_r <= clamp_nxt;
        pos_e2_r  <= pos_e1_r;
        pos_e1_r  <= e_r;
      end else begin
        spd_acc_r <= clamp_nxt;
        spd_e2_r  <= spd_e1_r;
        spd_e1_r  <= e_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mode_r   <= in_data.mode;
        target_r <= sat_i(in_data.target);
        angle_r  <= sat_i(in_data.angle_feedback);
        rpm_r    <= sat_i(in_data.rpm_feedback);
        sp_r     <= sat_i(in_data.target);
      end
      OP_ERR:  e_r <= e_nxt;
      OP_DIFF: begin
        d1_r  <= d1_nxt;
        d2_r  <= d2_nxt;
        sum_r <= ext2(acc_v);
      end
      OP_MLO:  plo_r  <= plo_nxt;
      OP_MHI:  phi_r  <= phi_nxt;
      OP_PROD: prod_r <= prod_nxt;
      OP_ACC:  sum_r  <= sum_nxt;
      OP_CLAMP: begin
        if (cmd.loop_pos) begin
          sp_r <= clamp_nxt;
        end
      end
      OP_OUT: begin
        out_data_r.drive          <= to_field(spd_acc_r);
        out_data_r.speed_setpoint <= to_field(sp_r);
      end
      default: ;
    endcase
  end

endmodule

### src/cascaded_incremental_pid_servo.sv
// One request at a time: in_stall is high from accept until the output step, which waits
// while the output is stalled. Position mode runs the position loop, whose clamped result is
// the speed setpoint, then the speed loop; each loop runs error and difference steps, three
// gain terms on one shared multiplier (two half-width partial products each) and a clamp step.
// Reset: rst_n synchronous active low; clears loop state, gains to zero, limits to full scale.
`timescale 1ns / 1ps

module cascaded_incremental_pid_servo #(
  parameter int FRAC_BITS = cips_pkg::FRAC_BITS_DEF,
  parameter int DATA_BITS = cips_pkg::DATA_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cips_pkg::in_req_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cips_pkg::out_rsp_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cips_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cips_pkg::FIELD_W-1:0]   cfg_data
);
  import cips_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cips_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cips_dp #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
